// ===== rtl/core/rfs_pkg.sv =====
// Package for the RGB fade sequencer: commands, widths and defaults.
package rfs_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int LEVEL_BITS_DEF  = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam int CMD_W = 3;
    localparam int IN_W  = 17;
    localparam int CFG_W = 16;
    localparam int OUT_W = 16;
    localparam int STEP_W = 16;
    localparam int DUR_W  = 32;

    localparam logic [CMD_W-1:0] CMD_SET_NOW = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARKER  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    localparam logic [CFG_W-1:0] RANGE_RESET = 16'd255;

endpackage

// ===== rtl/core/rfs_divider.sv =====
// Restoring divider for the fade math: one quotient bit per cycle.
module rfs_divider
    import rfs_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   n_trial;
    logic             n_ge;

    // Shift in one numerator bit and try the subtract
    assign n_trial = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_den};

    // Step the divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= n_ge ? (n_trial - {1'b0, r_den}) : n_trial;
            r_quot <= {r_quot[NUM_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[DEN_W-1:0];
endmodule

// ===== rtl/core/rgb_fade_sequencer.sv =====
// Top level of the RGB fade sequencer: list memory and command sequencer.
//
//  channel | dir | handshake          | payload
//  in      | in  | i_valid / o_ready  | command, red/green/blue_in, step_count, duration_ms
//  out     | out | o_valid / i_ready  | red/green/blue_out
//  cfg     | in  | i_cfg_we           | i_cfg_wdata (write_range)
//
// One item at a time. Each item first reads the list; clear then ends,
// set_now drives its colour, and append, markers and ticks are evaluated.
// A fade step adds four 48 bit divides on one shared bit-serial divider
// plus the channel hand-offs. Reset (synchronous, i_rst_n low) empties
// the list; memory needs no clear. A result waits in the output register;
// the next item is still taken while it waits, but an item that drives a
// colour holds until it drains.
module rgb_fade_sequencer
    import rfs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int LEVEL_BITS  = LEVEL_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic signed [IN_W-1:0] i_red_in,
    input  logic signed [IN_W-1:0] i_green_in,
    input  logic signed [IN_W-1:0] i_blue_in,
    input  logic [STEP_W-1:0] i_step_count,
    input  logic [DUR_W-1:0]  i_duration_ms,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OUT_W-1:0]  o_red_out,
    output logic [OUT_W-1:0]  o_green_out,
    output logic [OUT_W-1:0]  o_blue_out
);
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int TOT_W = $clog2(MAX_ENTRIES + 1);
    localparam int LV_W  = LEVEL_BITS;
    localparam int DL_W  = LEVEL_BITS + 1;
    localparam int TM_W  = TIME_BITS;
    localparam int NUM_W = TIME_BITS + STEP_W;
    localparam int ENT_W = 3 * LV_W + 3 * DL_W + STEP_W + TM_W;
    localparam logic [LV_W-1:0] LMAX = {LV_W{1'b1}};
    localparam logic [TM_W-1:0] TMAX = {TM_W{1'b1}};

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_EVAL  = 8'b0000_0100,
        S_DSTEP = 8'b0000_1000,
        S_MSTEP = 8'b0001_0000,
        S_DCH   = 8'b0010_0000,
        S_CCH   = 8'b0100_0000,
        S_DRIVE = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [LV_W-1:0] r, g, b;
        logic signed [DL_W-1:0] dr, dg, db;
        logic [STEP_W-1:0] steps;
        logic [TM_W-1:0] dur;
    } t_entry;

    t_state r_state, n_state;
    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd;
    logic [TOT_W-1:0] r_total;
    logic [IDX_W-1:0] r_active;
    logic [TM_W-1:0]  r_elapsed;
    logic [STEP_W-1:0] r_step;
    logic [LV_W-1:0]  r_cur [3];
    logic [LV_W-1:0]  r_range;
    logic [CMD_W-1:0] r_cmd;
    logic [LV_W-1:0]  r_c [3];
    logic [STEP_W-1:0] r_steps_in;
    logic [TM_W-1:0]  r_dur_in;
    logic             r_ovalid;
    logic [LV_W-1:0]  r_out [3];
    logic [NUM_W-1:0] r_slot;
    logic [1:0]       r_ch;
    logic             r_tail;

    // Clamp incoming levels
    function automatic logic [LV_W-1:0] clamp(input logic signed [IN_W-1:0] v,
                                               input logic [LV_W-1:0] rng);
        logic [IN_W-1:0] u;
        u = v;
        if (v < 0) return '0;
        if (u > IN_W'(rng)) return rng;
        return LV_W'(u);
    endfunction

    // Fold the configured range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_range <= LV_W'(RANGE_RESET);
        else if (i_cfg_we) begin
            if (i_cfg_wdata == '0) r_range <= LV_W'(1);
            else if (i_cfg_wdata > CFG_W'(LMAX)) r_range <= LMAX;
            else r_range <= LV_W'(i_cfg_wdata);
        end
    end

    logic accept;
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // Append arithmetic: start, deltas, step clamp
    logic [LV_W-1:0] prev [3];
    logic signed [DL_W-1:0] dlt [3];
    logic [LV_W-1:0] mag [3];
    logic [LV_W-1:0] maxd;
    logic [STEP_W-1:0] st_cl;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prev[k] = (r_total != '0) ? (k == 0 ? r_rd.r : k == 1 ? r_rd.g : r_rd.b)
                                      : r_cur[k];
            dlt[k] = $signed({1'b0, r_c[k]}) - $signed({1'b0, prev[k]});
            mag[k] = dlt[k][DL_W-1] ? LV_W'(-dlt[k]) : LV_W'(dlt[k]);
        end
        maxd = mag[0];
        if (mag[1] > maxd) maxd = mag[1];
        if (mag[2] > maxd) maxd = mag[2];
        st_cl = (r_steps_in > STEP_W'(maxd)) ? STEP_W'(maxd) : r_steps_in;
    end

    // Shared divider
    logic dv_start, dv_done;
    logic [NUM_W-1:0] dv_num, dv_quot;
    logic [STEP_W-1:0] dv_rem;
    rfs_divider #(.NUM_W(NUM_W), .DEN_W(STEP_W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start),
        .i_num(dv_num), .i_den(r_rd.steps),
        .o_done(dv_done), .o_quot(dv_quot), .o_rem(dv_rem)
    );

    // Channel under work in the fade step
    logic signed [DL_W-1:0] ch_d;
    logic [LV_W-1:0] ch_t;
    logic [LV_W-1:0] ch_m;
    logic [NUM_W-1:0] prod;
    always_comb begin
        case (r_ch)
            2'd0:    begin ch_d = r_rd.dr; ch_t = r_rd.r; end
            2'd1:    begin ch_d = r_rd.dg; ch_t = r_rd.g; end
            default: begin ch_d = r_rd.db; ch_t = r_rd.b; end
        endcase
        ch_m = ch_d[DL_W-1] ? LV_W'(-ch_d) : LV_W'(ch_d);
        prod = NUM_W'(r_step) * NUM_W'(ch_m);
    end

    logic [LV_W-1:0] n_col;
    logic [LV_W-1:0] part;
    always_comb begin
        part = LV_W'(dv_quot) + LV_W'(((dv_rem != '0) && !ch_d[DL_W-1]) ? 1 : 0);
        if (ch_d[DL_W-1]) n_col = LV_W'(ch_t + ch_m - part);
        else              n_col = LV_W'(ch_t - ch_m + part);
    end

    logic fire;
    assign fire = (r_rd.steps != '0) && (r_step < r_rd.steps) && (r_elapsed > r_slot[TM_W-1:0])
                  && (r_slot[NUM_W-1:TM_W] == '0);

    always_comb begin
        dv_start = 1'b0;
        dv_num   = '0;
        if (r_state == S_EVAL && r_cmd == CMD_TICK && !(r_elapsed > r_rd.dur)
            && r_rd.steps != '0 && r_step < r_rd.steps) begin
            dv_start = 1'b1;
            dv_num   = NUM_W'(r_rd.dur);
        end else if (r_state == S_MSTEP || r_state == S_CCH) begin
            dv_start = 1'b1;
            dv_num   = prod;
        end
    end

    // Memory: one write port, one registered read
    logic            mem_we;
    logic [IDX_W-1:0] mem_wa, mem_ra;
    t_entry          mem_wd;
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
    end

    always_comb begin
        mem_ra = (r_state == S_IDLE) ? '0 : r_active;
        if (r_state == S_READ && r_cmd != CMD_TICK) mem_ra = IDX_W'(r_total - 1'b1);
        if (r_state == S_READ && r_cmd == CMD_TICK && TOT_W'(r_active) >= r_total)
            mem_ra = '0;
        mem_we = 1'b0;
        mem_wa = IDX_W'(r_total);
        mem_wd = '{r: r_c[0], g: r_c[1], b: r_c[2], dr: dlt[0], dg: dlt[1], db: dlt[2],
                   steps: st_cl, dur: r_dur_in};
        if (r_state == S_EVAL && r_cmd == CMD_MARKER) begin
            mem_we = 1'b1;
            mem_wd = '{r: r_c[0], g: r_c[1], b: r_c[2], dr: '0, dg: '0, db: '0,
                       steps: STEP_W'(1), dur: '0};
        end else if (r_state == S_EVAL && r_cmd == CMD_APPEND && st_cl != '0)
            mem_we = 1'b1;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_active  <= '0;
            r_elapsed <= '0;
            r_step    <= STEP_W'(1);
            r_ovalid  <= 1'b0;
            for (int k = 0; k < 3; k++) r_cur[k] <= '0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd <= i_command;
                        r_c[0] <= clamp(i_red_in, r_range);
                        r_c[1] <= clamp(i_green_in, r_range);
                        r_c[2] <= clamp(i_blue_in, r_range);
                        r_steps_in <= i_step_count;
                        r_dur_in <= TM_W'(i_duration_ms);
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_IDLE;
                    case (r_cmd)
                        CMD_SET_NOW, CMD_CLEAR: begin
                            r_total <= '0; r_active <= '0;
                            r_elapsed <= '0; r_step <= STEP_W'(1);
                            if (r_cmd == CMD_SET_NOW) begin
                                for (int k = 0; k < 3; k++) r_out[k] <= r_c[k];
                                r_state <= S_DRIVE;
                            end
                        end
                        CMD_APPEND, CMD_MARKER:
                            if (r_total < TOT_W'(MAX_ENTRIES)) r_state <= S_EVAL;
                        CMD_TICK:
                            if (r_total != '0) begin
                                if (TOT_W'(r_active) >= r_total) r_active <= '0;
                                r_state <= S_EVAL;
                            end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_EVAL: begin
                    r_state <= S_IDLE;
                    if (r_cmd == CMD_MARKER || r_cmd == CMD_APPEND) begin
                        if (mem_we) r_total <= r_total + 1'b1;
                    end else if (r_elapsed > r_rd.dur) begin
                        r_out[0] <= r_rd.r; r_out[1] <= r_rd.g; r_out[2] <= r_rd.b;
                        r_step <= STEP_W'(1);
                        r_elapsed <= '0;
                        r_active <= (TOT_W'(r_active) + 1'b1 < r_total) ? r_active + 1'b1 : '0;
                        r_state <= S_DRIVE;
                    end else begin
                        r_tail <= (r_rd.steps == STEP_W'(1));
                        r_out[0] <= r_rd.r; r_out[1] <= r_rd.g; r_out[2] <= r_rd.b;
                        if (dv_start) r_state <= S_DSTEP;
                        else begin
                            if (r_elapsed != TMAX) r_elapsed <= r_elapsed + 1'b1;
                            if (r_rd.steps == STEP_W'(1)) r_state <= S_DRIVE;
                        end
                    end
                end
                S_DSTEP: if (dv_done) begin
                    r_slot <= NUM_W'(dv_quot[TM_W-1:0]) * NUM_W'(r_step);
                    r_ch <= 2'd0;
                    r_state <= S_MSTEP;
                end
                S_MSTEP: begin
                    if (fire) r_state <= S_DCH;
                    else begin
                        if (r_elapsed != TMAX) r_elapsed <= r_elapsed + 1'b1;
                        r_state <= r_tail ? S_DRIVE : S_IDLE;
                    end
                end
                S_DCH: if (dv_done) begin
                    r_out[r_ch] <= n_col;
                    if (r_ch == 2'd2) begin
                        r_step <= r_step + 1'b1;
                        if (r_elapsed != TMAX) r_elapsed <= r_elapsed + 1'b1;
                        r_state <= S_DRIVE;
                    end else begin
                        r_ch <= r_ch + 1'b1;
                        r_state <= S_CCH;
                    end
                end
                // Start the divide for the next channel
                S_CCH: r_state <= S_DCH;
                S_DRIVE: if (!r_ovalid || i_ready) begin
                    r_ovalid <= 1'b1;
                    for (int k = 0; k < 3; k++) r_cur[k] <= r_out[k];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_red_out   = OUT_W'(r_cur[0]);
    assign o_green_out = OUT_W'(r_cur[1]);
    assign o_blue_out  = OUT_W'(r_cur[2]);
endmodule

// ===== rtl/core/rfs_checker.sv =====
// Port-level checks for the RGB fade sequencer, bound to the top level.
module rfs_checker
    import rfs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic [CMD_W-1:0] i_command,
    input logic             o_valid,
    input logic             i_ready,
    input logic [OUT_W-1:0] o_red_out
);
    // Hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_red_out))
        else $error("result beat dropped or changed while stalled");

    // One item at a time: no ready right after an accept
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after accept");

    // Clear never produces a result
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_command == CMD_CLEAR && !o_valid |=> ##1 !o_valid)
        else $error("clear produced a result");

    // Nothing valid right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind rgb_fade_sequencer rfs_checker u_rfs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_command(i_command), .o_valid(o_valid), .i_ready(i_ready),
    .o_red_out(o_red_out)
);
